[sv/ckblit_pkg.sv]
// Shared types, constants and helpers for the color keyed sprite blitter.
package ckblit_pkg;

    // Default screen and image limits
    localparam int DEF_SCREEN_WIDTH   = 1920;
    localparam int DEF_SCREEN_HEIGHT  = 1080;
    localparam int DEF_MAX_IMAGE_SIDE = 4096;

    // Field widths
    localparam int POS_W   = 12;
    localparam int SIDE_W  = 13;
    localparam int COLOR_W = 32;
    localparam int INDEX_W = 21;
    localparam int PROD_W  = 25;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 13;

    // Alpha key
    localparam int          ALPHA_SHIFT  = 24;
    localparam logic [7:0]  OPAQUE_ALPHA = 8'hff;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_COL   = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_ROW   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COPY_WIDTH   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COPY_HEIGHT  = 4'd7;

    // Configuration register file
    typedef struct packed {
        logic [POS_W-1:0]  window_left;
        logic [POS_W-1:0]  window_top;
        logic [SIDE_W-1:0] image_width;
        logic [SIDE_W-1:0] image_height;
        logic [POS_W-1:0]  target_col;
        logic [POS_W-1:0]  target_row;
        logic [SIDE_W-1:0] copy_width;
        logic [SIDE_W-1:0] copy_height;
    } cfg_t;

    // Clipped pixel on its way to the index stage
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [POS_W-1:0]   scol;
        logic [POS_W-1:0]   srow;
    } clip_pixel_t;

    // Force an image side into 1..max_side
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v,
                                                     input logic [SIDE_W-1:0] max_side);
        logic [SIDE_W-1:0] r;
        if (v == '0) begin
            r = SIDE_W'(1);
        end else if (v > max_side) begin
            r = max_side;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[sv/ckblit_pos_counter.sv]
// Raster position counter that tracks the column and row of the next source pixel.
module ckblit_pos_counter
    import ckblit_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic [SIDE_W-1:0] eff_width,
    input  logic [SIDE_W-1:0] eff_height,
    output logic [POS_W-1:0]  column,
    output logic [POS_W-1:0]  row
);

    logic [POS_W-1:0]  column_reg, column_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [SIDE_W-1:0] column_inc;
    logic [SIDE_W-1:0] row_inc;

    // Step to the next pixel, wrapping at the image edges
    always_comb begin
        column_inc  = {1'b0, column_reg} + SIDE_W'(1);
        row_inc     = {1'b0, row_reg} + SIDE_W'(1);
        column_next = column_reg;
        row_next    = row_reg;
        if (advance) begin
            if (column_inc >= eff_width) begin
                column_next = '0;
                row_next    = (row_inc >= eff_height) ? '0 : row_inc[POS_W-1:0];
            end else begin
                column_next = column_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
        end else begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    assign column = column_reg;
    assign row    = row_reg;

endmodule

[sv/ckblit_clip_stage.sv]
// Window, alpha key and screen clip test with its pipeline register.
module ckblit_clip_stage
    import ckblit_pkg::*;
#(
    parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic [SIDE_W-1:0]  eff_width,
    input  logic [SIDE_W-1:0]  eff_height,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [COLOR_W-1:0] in_color,
    input  logic [POS_W-1:0]   in_column,
    input  logic [POS_W-1:0]   in_row,
    output logic               out_valid,
    input  logic               out_ready,
    output clip_pixel_t        out_pixel
);

    logic              valid_reg, valid_next;
    clip_pixel_t       pixel_reg, pixel_next;
    logic [SIDE_W-1:0] copy_w, copy_h;
    logic [POS_W-1:0]  dx, dy;
    logic [SIDE_W-1:0] scol, srow;
    logic              x_in, y_in, opaque, x_on, y_on, take;

    // Locate the pixel in the window and on the screen
    always_comb begin
        copy_w = (cfg.copy_width == '0) ? eff_width : cfg.copy_width;
        copy_h = (cfg.copy_height == '0) ? eff_height : cfg.copy_height;
        dx     = in_column - cfg.window_left;
        dy     = in_row - cfg.window_top;
        x_in   = (in_column >= cfg.window_left) && ({1'b0, dx} < copy_w);
        y_in   = (in_row >= cfg.window_top) && ({1'b0, dy} < copy_h);
        opaque = (in_color[ALPHA_SHIFT +: 8] == OPAQUE_ALPHA);
        scol   = {1'b0, cfg.target_col} + {1'b0, dx};
        srow   = {1'b0, cfg.target_row} + {1'b0, dy};
        x_on   = scol < SIDE_W'(SCREEN_WIDTH);
        y_on   = srow < SIDE_W'(SCREEN_HEIGHT);
        take   = x_in && y_in && opaque && x_on && y_on;
    end

    assign in_ready = !valid_reg || out_ready;

    // Load when the stage moves; drop pixels that are not copied
    always_comb begin
        valid_next = valid_reg;
        pixel_next = pixel_reg;
        if (in_ready) begin
            valid_next       = in_valid && take;
            pixel_next.color = in_color;
            pixel_next.scol  = scol[POS_W-1:0];
            pixel_next.srow  = srow[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pixel_reg <= pixel_next;
    end

    assign out_valid = valid_reg;
    assign out_pixel = pixel_reg;

endmodule

[sv/ckblit_index_stage.sv]
// Framebuffer index computation and result register.
module ckblit_index_stage
    import ckblit_pkg::*;
#(
    parameter int SCREEN_WIDTH = DEF_SCREEN_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  clip_pixel_t        in_pixel,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [INDEX_W-1:0] m_screen_index,
    output logic [COLOR_W-1:0] m_write_color
);

    logic               valid_reg, valid_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [PROD_W-1:0]  index_full;

    // Row times screen width plus column
    assign index_full = PROD_W'(in_pixel.srow) * PROD_W'(SCREEN_WIDTH)
                      + PROD_W'(in_pixel.scol);

    assign in_ready = !valid_reg || m_ready;

    // Hold the result until the downstream side takes it
    always_comb begin
        valid_next = valid_reg;
        index_next = index_reg;
        color_next = color_reg;
        if (in_ready) begin
            valid_next = in_valid;
            index_next = index_full[INDEX_W-1:0];
            color_next = in_pixel.color;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        index_reg <= index_next;
        color_reg <= color_next;
    end

    assign m_valid        = valid_reg;
    assign m_screen_index = index_reg;
    assign m_write_color  = color_reg;

endmodule

[sv/color_keyed_sprite_blit_unit.sv]
// Top level of the color keyed sprite blitter: registers, input stage and pipeline.
// Pipeline: input register, clip register and result register, in that order; a result
// is held in the result register while m_ready is low.
// Throughput: one pixel per cycle unless m_ready low holds the three pipeline registers.
// Reset (aresetn low, synchronous): pipeline emptied, position counters at column and
// row 0, registers to 0 except image width and height, which go to 1.
module color_keyed_sprite_blit_unit
    import ckblit_pkg::*;
#(
    parameter int SCREEN_WIDTH   = DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT  = DEF_SCREEN_HEIGHT,
    parameter int MAX_IMAGE_SIDE = DEF_MAX_IMAGE_SIDE
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [COLOR_W-1:0]    s_pixel_color,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [INDEX_W-1:0]    m_screen_index,
    output logic [COLOR_W-1:0]    m_write_color,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t               cfg_reg, cfg_next;
    logic [SIDE_W-1:0]  eff_width, eff_height;
    logic               in_valid_reg, in_valid_next;
    logic [COLOR_W-1:0] in_color_reg, in_color_next;
    logic [POS_W-1:0]   in_column_reg, in_column_next;
    logic [POS_W-1:0]   in_row_reg, in_row_next;
    logic [POS_W-1:0]   column, row;
    logic               s_accept;
    logic               clip_ready;
    logic               clip_valid;
    clip_pixel_t        clip_pixel;
    logic               index_ready;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    // Decode register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_WINDOW_LEFT:  cfg_next.window_left  = cfg_data[POS_W-1:0];
                REG_WINDOW_TOP:   cfg_next.window_top   = cfg_data[POS_W-1:0];
                REG_IMAGE_WIDTH:  cfg_next.image_width  = cfg_data[SIDE_W-1:0];
                REG_IMAGE_HEIGHT: cfg_next.image_height = cfg_data[SIDE_W-1:0];
                REG_TARGET_COL:   cfg_next.target_col   = cfg_data[POS_W-1:0];
                REG_TARGET_ROW:   cfg_next.target_row   = cfg_data[POS_W-1:0];
                REG_COPY_WIDTH:   cfg_next.copy_width   = cfg_data[SIDE_W-1:0];
                REG_COPY_HEIGHT:  cfg_next.copy_height  = cfg_data[SIDE_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_left  <= '0;
            cfg_reg.window_top   <= '0;
            cfg_reg.image_width  <= SIDE_W'(1);
            cfg_reg.image_height <= SIDE_W'(1);
            cfg_reg.target_col   <= '0;
            cfg_reg.target_row   <= '0;
            cfg_reg.copy_width   <= '0;
            cfg_reg.copy_height  <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Effective image size
    assign eff_width  = clamp_side(cfg_reg.image_width, SIDE_W'(MAX_IMAGE_SIDE));
    assign eff_height = clamp_side(cfg_reg.image_height, SIDE_W'(MAX_IMAGE_SIDE));

    ckblit_pos_counter u_pos_counter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (s_accept),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .column     (column),
        .row        (row)
    );

    // Input register: pixel and its position
    assign s_ready  = !in_valid_reg || clip_ready;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_color_next  = in_color_reg;
        in_column_next = in_column_reg;
        in_row_next    = in_row_reg;
        if (s_ready) begin
            in_valid_next  = s_valid;
            in_color_next  = s_pixel_color;
            in_column_next = column;
            in_row_next    = row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_color_reg  <= in_color_next;
        in_column_reg <= in_column_next;
        in_row_reg    <= in_row_next;
    end

    ckblit_clip_stage #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_clip_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .eff_width  (eff_width),
        .eff_height (eff_height),
        .in_valid   (in_valid_reg),
        .in_ready   (clip_ready),
        .in_color   (in_color_reg),
        .in_column  (in_column_reg),
        .in_row     (in_row_reg),
        .out_valid  (clip_valid),
        .out_ready  (index_ready),
        .out_pixel  (clip_pixel)
    );

    ckblit_index_stage #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_index_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (clip_valid),
        .in_ready       (index_ready),
        .in_pixel       (clip_pixel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_screen_index (m_screen_index),
        .m_write_color  (m_write_color)
    );

    // Only opaque pixels reach the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_write_color[ALPHA_SHIFT +: 8] == OPAQUE_ALPHA))
        else $error("non-opaque pixel on result channel");

    // An accepted transaction always lands in the input register
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> in_valid_reg)
        else $error("accepted pixel lost at input register");

    // Input stalls only when the input register is full and the clip stage is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && clip_valid && !index_ready))
        else $error("input stalled without a full pipeline");

    // Result register is full whenever the clip stage is blocked
    assert property (@(posedge aclk) disable iff (!aresetn)
        !index_ready |-> (m_valid && !m_ready))
        else $error("index stage stalled without a pending result");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the color keyed sprite blitter: pixel stream, register writes, checks.
module testbench
    import ckblit_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CLK_PERIOD   = 12;
    localparam int unsigned SCREEN_W     = DEF_SCREEN_WIDTH;
    localparam int unsigned SCREEN_H     = DEF_SCREEN_HEIGHT;
    localparam int unsigned MAX_SIDE     = DEF_MAX_IMAGE_SIDE;
    localparam int          PIXEL_TARGET = 850;
    localparam int          CALM_FROM    = 750;
    localparam int          SETTLE_PAD   = 8;
    localparam int          STUCK_LIMIT  = 2000;

    // Predicts the framebuffer writes from the pixel stream and checks the block against them
    class blit_write_checker;
        typedef struct {
            logic [INDEX_W-1:0] index;
            logic [COLOR_W-1:0] color;
        } fb_write_t;

        cfg_t             regs;
        logic [POS_W-1:0] src_col;
        logic [POS_W-1:0] src_row;
        fb_write_t        expected_writes[$];
        int               errors;

        function new();
            regs = '0;
            regs.image_width = SIDE_W'(1);
            regs.image_height = SIDE_W'(1);
            src_col = '0;
            src_row = '0;
            errors = 0;
        endfunction

        // Register writes leave the position counters alone
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_WINDOW_LEFT:  regs.window_left  = data[POS_W-1:0];
                REG_WINDOW_TOP:   regs.window_top   = data[POS_W-1:0];
                REG_IMAGE_WIDTH:  regs.image_width  = data;
                REG_IMAGE_HEIGHT: regs.image_height = data;
                REG_TARGET_COL:   regs.target_col   = data[POS_W-1:0];
                REG_TARGET_ROW:   regs.target_row   = data[POS_W-1:0];
                REG_COPY_WIDTH:   regs.copy_width   = data;
                REG_COPY_HEIGHT:  regs.copy_height  = data;
                default: ;
            endcase
        endfunction

        // Zero counts as one, anything past the largest side is held at it
        function int unsigned eff_width();
            if (regs.image_width == 0) return 1;
            return (regs.image_width > MAX_SIDE) ? MAX_SIDE : regs.image_width;
        endfunction

        function int unsigned eff_height();
            if (regs.image_height == 0) return 1;
            return (regs.image_height > MAX_SIDE) ? MAX_SIDE : regs.image_height;
        endfunction

        function void note_pixel(logic [COLOR_W-1:0] color);
            int unsigned w, h, cw, ch, dx, dy, scol, srow;
            fb_write_t   wr;
            w = eff_width();
            h = eff_height();
            cw = (regs.copy_width == 0) ? w : regs.copy_width;
            ch = (regs.copy_height == 0) ? h : regs.copy_height;
            // A position left of the window wraps to a huge offset and fails the length test
            dx = int'(src_col) - int'(regs.window_left);
            dy = int'(src_row) - int'(regs.window_top);
            if (dx < cw && dy < ch && color[COLOR_W-1:ALPHA_SHIFT] == OPAQUE_ALPHA) begin
                scol = regs.target_col + dx;
                srow = regs.target_row + dy;
                if (scol < SCREEN_W && srow < SCREEN_H) begin
                    wr.index = INDEX_W'(srow * SCREEN_W + scol);
                    wr.color = color;
                    expected_writes.push_back(wr);
                end
            end
            // Advance in raster order, wrapping to the next image after the last row
            if (int'(src_col) + 1 >= w) begin
                src_col = '0;
                src_row = (int'(src_row) + 1 >= h) ? '0 : POS_W'(src_row + 1);
            end else begin
                src_col = POS_W'(src_col + 1);
            end
        endfunction

        function void check_result(logic [INDEX_W-1:0] index, logic [COLOR_W-1:0] color);
            fb_write_t exp_wr;
            if (expected_writes.size() == 0) begin
                errors++;
                $display("%0t: unexpected write, index %0d color %08h", $time, index, color);
                return;
            end
            exp_wr = expected_writes.pop_front();
            if (index !== exp_wr.index) begin
                errors++;
                $display("%0t: screen_index expected %0d actual %0d", $time, exp_wr.index,
                         index);
            end
            if (color !== exp_wr.color) begin
                errors++;
                $display("%0t: write_color expected %08h actual %08h", $time, exp_wr.color,
                         color);
            end
        endfunction

        function int outstanding();
            return expected_writes.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [COLOR_W-1:0]    s_pixel_color = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [INDEX_W-1:0]    m_screen_index;
    logic [COLOR_W-1:0]    m_write_color;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    blit_write_checker writes_chk = new();
    int  pixels_sent = 0;
    int  stall_left = 0;
    int  stuck_cycles = 0;
    bit  idling_on = 1'b0;

    color_keyed_sprite_blit_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_pixel_color  (s_pixel_color),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_screen_index (m_screen_index),
        .m_write_color  (m_write_color),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Check each write transaction, then decide whether to stall the next cycle
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            writes_chk.check_result(m_screen_index, m_write_color);
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // End the run when nothing moves on any channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic send_pixel(input logic [COLOR_W-1:0] color);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_color <= color;
        do @(posedge aclk); while (!s_ready);
        writes_chk.note_pixel(color);
        pixels_sent++;
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        writes_chk.write_reg(idx, data);
    endtask

    // Hold the pixel stream until every expected write is out and the pipeline is empty
    task automatic settle();
        s_valid <= 1'b0;
        while (writes_chk.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_PAD) @(posedge aclk);
    endtask

    // Write the plan (all of it or a random part), junk in unused upper bits, maybe a dead index
    task automatic configure(input cfg_t plan, input bit all_regs);
        logic [CFG_DATA_W-1:0] vals[REG_COPY_HEIGHT + 1];
        vals[REG_WINDOW_LEFT]  = {1'($urandom_range(0, 1)), plan.window_left};
        vals[REG_WINDOW_TOP]   = {1'($urandom_range(0, 1)), plan.window_top};
        vals[REG_IMAGE_WIDTH]  = plan.image_width;
        vals[REG_IMAGE_HEIGHT] = plan.image_height;
        vals[REG_TARGET_COL]   = {1'($urandom_range(0, 1)), plan.target_col};
        vals[REG_TARGET_ROW]   = {1'($urandom_range(0, 1)), plan.target_row};
        vals[REG_COPY_WIDTH]   = plan.copy_width;
        vals[REG_COPY_HEIGHT]  = plan.copy_height;
        for (int r = 0; r <= REG_COPY_HEIGHT; r++) begin
            if (all_regs || $urandom_range(0, 2) != 0) begin
                write_cfg(CFG_IDX_W'(r), vals[r]);
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            write_cfg(CFG_IDX_W'($urandom_range(REG_COPY_HEIGHT + 1, (1 << CFG_IDX_W) - 1)),
                      CFG_DATA_W'($urandom()));
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SIDE_W-1:0] pick_side();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return SIDE_W'(MAX_SIDE);
            2: return '1;
            3: return SIDE_W'(1);
            default: return SIDE_W'($urandom_range(2, 24));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_window(int unsigned side);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return POS_W'(side);
            default: return POS_W'($urandom_range(0, side - 1));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_target(int unsigned screen_side);
        case ($urandom_range(0, 9))
            0: return POS_W'(screen_side - $urandom_range(1, 12));
            1: return '1;
            2: return POS_W'($urandom());
            default: return POS_W'($urandom_range(0, 60));
        endcase
    endfunction

    function automatic logic [SIDE_W-1:0] pick_copy(int unsigned side);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return '0;
            4: return SIDE_W'(side + $urandom_range(1, 5));
            5: return '1;
            default: return SIDE_W'($urandom_range(1, side));
        endcase
    endfunction

    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 7))
            0: return COLOR_W'($urandom());
            1: return {OPAQUE_ALPHA - 8'd1, 24'($urandom())};
            default: return {OPAQUE_ALPHA, 24'($urandom())};
        endcase
    endfunction

    // One random setting followed by mostly whole images of pixels
    task automatic random_phase();
        cfg_t        plan;
        int unsigned w, h, area, count;
        settle();
        idling_on = (pixels_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
        plan.image_width = pick_side();
        plan.image_height = pick_side();
        w = (plan.image_width == 0) ? 1 :
            ((plan.image_width > MAX_SIDE) ? MAX_SIDE : plan.image_width);
        h = (plan.image_height == 0) ? 1 :
            ((plan.image_height > MAX_SIDE) ? MAX_SIDE : plan.image_height);
        plan.window_left = pick_window(w);
        plan.window_top = pick_window(h);
        plan.target_col = pick_target(SCREEN_W);
        plan.target_row = pick_target(SCREEN_H);
        plan.copy_width = pick_copy(w);
        plan.copy_height = pick_copy(h);
        configure(plan, $urandom_range(0, 3) == 0);
        area = writes_chk.eff_width() * writes_chk.eff_height();
        if (area <= 60) begin
            count = area * $urandom_range(1, 3) + $urandom_range(0, 4);
        end else begin
            count = $urandom_range(10, 80);
        end
        if (count > 150) count = 150;
        // Stop at the pixel budget
        if (count > PIXEL_TARGET - pixels_sent) count = PIXEL_TARGET - pixels_sent;
        repeat (count) send_pixel(pick_color());
    endtask

    initial begin
        cfg_t d;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset setting: a 1x1 image at the screen origin, keyed on alpha alone
        send_pixel('1);
        send_pixel({OPAQUE_ALPHA, 24'h000000});
        send_pixel({OPAQUE_ALPHA - 8'd1, 24'hffffff});
        send_pixel(32'h7fffffff);
        send_pixel(32'h00ffffff);
        send_pixel({OPAQUE_ALPHA, 24'h5a5a5a});

        // 4x3 image, window from (1,1), landing on the bottom right corner: both clips hit
        settle();
        d = '0;
        d.window_left = POS_W'(1);
        d.window_top = POS_W'(1);
        d.image_width = SIDE_W'(4);
        d.image_height = SIDE_W'(3);
        d.target_col = POS_W'(SCREEN_W - 2);
        d.target_row = POS_W'(SCREEN_H - 1);
        configure(d, 1'b1);
        repeat (12) send_pixel({OPAQUE_ALPHA, 24'($urandom())});

        // Window starts right of the image: drop everything
        settle();
        d.window_left = POS_W'(9);
        d.target_col = '0;
        d.target_row = '0;
        configure(d, 1'b1);
        repeat (4) send_pixel({OPAQUE_ALPHA, 24'($urandom())});

        while (pixels_sent < PIXEL_TARGET) random_phase();

        s_valid <= 1'b0;
        while (writes_chk.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_PAD) @(posedge aclk);
        if (writes_chk.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
